// ===== hw/rtl/i2c_ram_pkg.sv =====
// shared types, constants and sequencing helpers of the i2c register access master
`default_nettype none

package i2c_ram_pkg;

  // reset value of the seven-bit slave address
  localparam logic [6:0] DevAddrReset = 7'd109;

  // tick queue between front and back
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueDepth = 1 << QueuePtrW;

  // command codes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  // sequencer steps, one-hot
  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_START  = 14'h0002,
    S_DEVW   = 14'h0004,
    S_ACK1   = 14'h0008,
    S_REG    = 14'h0010,
    S_ACK2   = 14'h0020,
    S_DATA   = 14'h0040,
    S_ACK3   = 14'h0080,
    S_RSTART = 14'h0100,
    S_DEVR   = 14'h0200,
    S_ACK4   = 14'h0400,
    S_RECV   = 14'h0800,
    S_MNACK  = 14'h1000,
    S_STOP   = 14'h2000
  } step_e;

  // one classified bus tick
  typedef struct packed {
    logic       go;
    logic       is_read;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda;
  } item_t;

  // step that follows a finished segment
  function automatic step_e next_step(step_e s, logic rd);
    step_e n;
    case (s)
      S_START:  n = S_DEVW;
      S_DEVW:   n = S_ACK1;
      S_ACK1:   n = S_REG;
      S_REG:    n = S_ACK2;
      S_ACK2:   n = rd ? S_RSTART : S_DATA;
      S_DATA:   n = S_ACK3;
      S_ACK3:   n = S_STOP;
      S_RSTART: n = S_DEVR;
      S_DEVR:   n = S_ACK4;
      S_ACK4:   n = S_RECV;
      S_RECV:   n = S_MNACK;
      S_MNACK:  n = S_STOP;
      default:  n = S_IDLE;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_ram_front.sv =====
// front end: takes bus ticks and decodes the command into a queue item
`default_nettype none

module i2c_ram_front
  import i2c_ram_pkg::*;
(
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] register_address_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic       sda_in_i,
  output logic            push_o,
  output item_t           item_o,
  input  wire logic       full_i
);

  cmd_e cmd;

  // transfer handshake toward the queue
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // command decode, the reserved code acts like no command
  always_comb begin
    cmd = cmd_e'(command_i);
    item_o.go       = 1'b0;
    item_o.is_read  = 1'b0;
    case (cmd)
      CMD_WRITE: item_o.go = 1'b1;
      CMD_READ: begin
        item_o.go      = 1'b1;
        item_o.is_read = 1'b1;
      end
      default: item_o.go = 1'b0;
    endcase
    item_o.reg_addr = register_address_i;
    item_o.wr_data  = write_data_i;
    item_o.sda      = sda_in_i;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_ram_queue.sv =====
// small tick queue between front and back
`default_nettype none

module i2c_ram_queue
  import i2c_ram_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o,
  input  wire logic  pop_i
);

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o  = count_q == (QueuePtrW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_ram_back.sv =====
// back end: bus sequencer, address register and result register
`default_nettype none

module i2c_ram_back
  import i2c_ram_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       item_valid_i,
  input  item_t           item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            scl_o,
  output logic            sda_out_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      read_data_o,
  output logic            nack_seen_o
);

  step_e      state_q, state_d, cur;
  logic [2:0] bitpos_q, bitpos_d;
  logic       half_q, half_d;
  logic       is_read_q, is_read_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] data_q, data_d;
  logic [7:0] rx_q, rx_d;
  logic       nack_q, nack_d;
  logic [6:0] dev_addr_q;
  logic [7:0] tx_byte;
  logic       scl, sdo, busy, done;
  logic       out_valid_q;
  logic       scl_q, sda_q, busy_q, done_q;

  // one tick is executed whenever the result register is free or drains
  assign pop_o = item_valid_i && (!out_valid_q || out_ready_i);

  // sequencer step for the tick at the head of the queue
  always_comb begin
    state_d   = state_q;
    bitpos_d  = bitpos_q;
    half_d    = half_q;
    is_read_d = is_read_q;
    reg_d     = reg_q;
    data_d    = data_q;
    rx_d      = rx_q;
    nack_d    = nack_q;
    scl       = 1'b1;
    sdo       = 1'b1;
    busy      = 1'b0;
    done      = 1'b0;
    cur       = state_q;

    // a command taken while idle starts the transaction on this same tick
    if (state_q == S_IDLE && item_i.go) begin
      cur       = S_START;
      is_read_d = item_i.is_read;
      reg_d     = item_i.reg_addr;
      data_d    = item_i.wr_data;
      nack_d    = 1'b0;
      bitpos_d  = '0;
      half_d    = 1'b0;
    end

    case (cur)
      S_DEVW:  tx_byte = {dev_addr_q, 1'b0};
      S_REG:   tx_byte = reg_q;
      S_DATA:  tx_byte = data_q;
      default: tx_byte = {dev_addr_q, 1'b1};
    endcase

    state_d = cur;
    case (cur)
      // start and repeated start
      S_START, S_RSTART: begin
        busy = 1'b1;
        scl  = bitpos_d < 3'd2;
        sdo  = bitpos_d == 3'd0;
        if (bitpos_d >= 3'd2) begin
          bitpos_d = '0;
          state_d  = next_step(cur, is_read_d);
        end else begin
          bitpos_d = bitpos_d + 3'd1;
        end
      end
      // stop, last tick flags done
      S_STOP: begin
        busy = 1'b1;
        scl  = bitpos_d != 3'd0;
        sdo  = bitpos_d == 3'd2;
        done = bitpos_d >= 3'd2;
        if (bitpos_d >= 3'd2) begin
          bitpos_d = '0;
          state_d  = next_step(cur, is_read_d);
        end else begin
          bitpos_d = bitpos_d + 3'd1;
        end
      end
      // clocked bit slots: sent bits, received bits, acks, master nack
      S_DEVW, S_REG, S_DATA, S_DEVR, S_RECV,
      S_ACK1, S_ACK2, S_ACK3, S_ACK4, S_MNACK: begin
        busy = 1'b1;
        scl  = !half_d;
        if (cur == S_DEVW || cur == S_REG || cur == S_DATA || cur == S_DEVR) begin
          sdo = tx_byte[~bitpos_d];
        end
        if (!half_d) begin
          if (cur == S_RECV) begin
            rx_d = {rx_q[6:0], item_i.sda};
          end else if (cur == S_ACK1 || cur == S_ACK2 || cur == S_ACK3 ||
                       cur == S_ACK4) begin
            nack_d = nack_d | item_i.sda;
          end
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if ((cur == S_DEVW || cur == S_REG || cur == S_DATA || cur == S_DEVR ||
               cur == S_RECV) && bitpos_d != 3'd7) begin
            bitpos_d = bitpos_d + 3'd1;
          end else begin
            bitpos_d = '0;
            state_d  = next_step(cur, is_read_d);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // device address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // sequencer state, advanced once per executed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bitpos_q  <= '0;
      half_q    <= 1'b0;
      is_read_q <= 1'b0;
      reg_q     <= '0;
      data_q    <= '0;
      rx_q      <= '0;
      nack_q    <= 1'b0;
    end else if (pop_o) begin
      state_q   <= state_d;
      bitpos_q  <= bitpos_d;
      half_q    <= half_d;
      is_read_q <= is_read_d;
      reg_q     <= reg_d;
      data_q    <= data_d;
      rx_q      <= rx_d;
      nack_q    <= nack_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      scl_q  <= scl;
      sda_q  <= sdo;
      busy_q <= busy;
      done_q <= done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = scl_q;
  assign sda_out_o   = sda_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign read_data_o = rx_q;
  assign nack_seen_o = nack_q;

  // the final stop tick releases both lines inside a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> busy_q && scl_q && sda_q)
    else $error("done tick without released bus");

  // an idle tick leaves both lines released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !busy_q |-> scl_q && sda_q && !done_q)
    else $error("idle tick drives the bus");

  // a done tick returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && done |=> state_q == S_IDLE)
    else $error("sequencer not idle after stop");

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_register_access_master.sv =====
// top level of the i2c register access master
`default_nettype none

// channel  direction  handshake                   payload
// in       input      in_valid_i / in_ready_o     command, register_address, write_data, sda_in
// out      output     out_valid_o / out_ready_i   scl, sda_out, busy_res, done_res, read_data,
//                                                 nack_seen
// cfg      input      cfg_we_i                    cfg_wdata_i (device address)
//
// one bus tick in gives one result out; one tick per cycle is sustained while out_ready_i
// keeps the result register draining, as the back end runs one sequencer step per tick.
// each tick passes through the four-entry tick queue and then the back end's result register.
// reset is asynchronous, active low, and leaves the sequencer idle with address 109.
// a stalled output fills the queue, then in_ready_o drops; the front keeps taking
// ticks until the queue is full.

module i2c_register_access_master
  import i2c_ram_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] register_address_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic       sda_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            scl_o,
  output logic            sda_out_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      read_data_o,
  output logic            nack_seen_o
);

  logic  push, full, head_valid, pop;
  item_t front_item, head_item;

  i2c_ram_front u_front (
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .register_address_i (register_address_i),
    .write_data_i       (write_data_i),
    .sda_in_i           (sda_in_i),
    .push_o             (push),
    .item_o             (front_item),
    .full_i             (full)
  );

  i2c_ram_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (head_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  i2c_ram_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (head_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_o        (scl_o),
    .sda_out_o    (sda_out_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_data_o  (read_data_o),
    .nack_seen_o  (nack_seen_o)
  );

endmodule

`default_nettype wire
